FILE: hw/rtl/pstb_pkg.sv
// shared types, codes and defaults for the periodic software timer bank
`default_nettype none

package pstb_pkg;

    localparam int NUM_TIMERS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_RESULTS     = 16;
    localparam int ACT_W           = 5;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_INIT  = 3'd1;
    localparam logic [2:0] FUNC_RUN   = 3'd2;
    localparam logic [2:0] FUNC_STOP  = 3'd3;
    localparam logic [2:0] FUNC_DELAY = 3'd4;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  timer_index;
        logic [31:0] interval_value;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  which_timer;
        logic [31:0] expiry_count;
        logic [31:0] ticks_so_far;
        logic        ok;
        logic        delay_busy;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_CMD
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/pstb_ram.sv
// generic single write, single read port ram with registered read data
`default_nettype none

module pstb_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is requested
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_software_timer_bank.sv
// periodic software timer bank: tick scan and command sequencer around one entry ram
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_ready  | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready| o_out_item (t_out_item)
//  cfg      | input     | i_cfg_we, no wait        | i_cfg_data (active timers)
//
// a command reads its entry in the acceptance cycle and writes back in S_CMD once the output
// register is free, where its result is registered
// a tick scans the active timers, at most MAX_RESULTS, one entry a cycle through the ram
// unless stalled; the final result is registered in S_FLUSH, then idle takes the next item
// each expiry is held one step so that the final one can carry last; a full output
// register stalls the scan when a held expiry must go out; the ram read data then holds
// synchronous active-low reset clears run flags, counters and the sequencer; entries
// never written read as zero through a per-entry written flag, so no clearing pass
`default_nettype none

module periodic_software_timer_bank
    import pstb_pkg::*;
#(
    parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data
);

    localparam int CW      = COUNT_WIDTH;
    localparam int AW      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ROW_W   = 3 * CW;
    localparam int MAX_ACT = (NUM_TIMERS < MAX_RESULTS) ? NUM_TIMERS : MAX_RESULTS;

    t_state              r_state, n_state;
    logic [ACT_W-1:0]    r_active, n_active;
    logic [NUM_TIMERS-1:0] r_running, n_running;
    logic [NUM_TIMERS-1:0] r_written, n_written;
    logic [CW-1:0]       r_tick, n_tick;
    logic [CW-1:0]       r_delay, n_delay;
    logic [ACT_W-1:0]    r_issue, n_issue;
    logic                r_proc_vld, n_proc_vld;
    logic [AW-1:0]       r_proc, n_proc;
    logic                r_pend_vld, n_pend_vld;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic [CW-1:0]       r_pend_cnt, n_pend_cnt;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out, n_out;
    logic [2:0]          r_func, n_func;
    logic [3:0]          r_cidx, n_cidx;
    logic [CW-1:0]       r_val, n_val;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata, rd_row;
    logic [CW-1:0]       rd_reload, rd_rem, rd_cyc, rem_dec, cyc_inc;
    logic [ACT_W-1:0]    n_eff;
    logic                out_free, hit, scan_stall, cmd_valid, cmd_ok;

    pstb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_TIMERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign n_eff     = (r_active > ACT_W'(MAX_ACT)) ? ACT_W'(MAX_ACT) : r_active;
    assign out_free  = !r_out_vld || i_out_ready;
    assign rd_row    = r_written[r_proc] ? ram_rdata : '0;
    assign rd_reload = rd_row[ROW_W-1:2*CW];
    assign rd_rem    = rd_row[2*CW-1:CW];
    assign rd_cyc    = rd_row[CW-1:0];
    assign rem_dec   = rd_rem - CW'(1);
    assign cyc_inc   = rd_cyc + CW'(1);
    assign hit       = r_proc_vld && r_running[r_proc] && (rem_dec == '0);
    assign scan_stall = (r_state == S_SCAN) && hit && r_pend_vld && !out_free;
    assign cmd_valid = {1'b0, r_cidx} < n_eff;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_running  = r_running;
        n_written  = r_written;
        n_tick     = r_tick;
        n_delay    = r_delay;
        n_issue    = r_issue;
        n_proc_vld = r_proc_vld;
        n_proc     = r_proc;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_pend_cnt = r_pend_cnt;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        n_func     = r_func;
        n_cidx     = r_cidx;
        n_val      = r_val;
        ram_we     = 1'b0;
        ram_waddr  = r_proc;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = r_proc;
        cmd_ok     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_item.func;
                    n_cidx = i_in_item.timer_index;
                    n_val  = CW'(i_in_item.interval_value);
                    if (i_in_item.func == FUNC_TICK) begin
                        n_tick = r_tick + CW'(1);
                        if (r_delay != '0) begin
                            n_delay = r_delay - CW'(1);
                        end
                        n_issue    = '0;
                        n_proc_vld = 1'b0;
                        n_pend_vld = 1'b0;
                        n_state    = S_SCAN;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(i_in_item.timer_index);
                        n_proc    = AW'(i_in_item.timer_index);
                        n_state   = S_CMD;
                    end
                end
            end

            S_SCAN: begin
                if (!scan_stall) begin
                    if (r_proc_vld && r_running[r_proc]) begin
                        ram_we            = 1'b1;
                        n_written[r_proc] = 1'b1;
                        if (hit) begin
                            ram_wdata = {rd_reload, rd_reload, cyc_inc};
                        end else begin
                            ram_wdata = {rd_reload, rem_dec, rd_cyc};
                        end
                    end
                    if (hit) begin
                        // the held expiry is not the final one, send it on
                        if (r_pend_vld) begin
                            n_out_vld          = 1'b1;
                            n_out.kind         = KIND_EXPIRY;
                            n_out.which_timer  = 4'(r_pend_idx);
                            n_out.expiry_count = 32'(r_pend_cnt);
                            n_out.ticks_so_far = 32'(r_tick);
                            n_out.ok           = 1'b1;
                            n_out.delay_busy   = (r_delay != '0);
                            n_out.last         = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_proc;
                        n_pend_cnt = cyc_inc;
                    end
                    if (r_issue < n_eff) begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(r_issue);
                        n_proc     = AW'(r_issue);
                        n_proc_vld = 1'b1;
                        n_issue    = r_issue + ACT_W'(1);
                    end else begin
                        n_proc_vld = 1'b0;
                        n_state    = S_FLUSH;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.kind         = r_pend_vld ? KIND_EXPIRY : KIND_ACK;
                    n_out.which_timer  = r_pend_vld ? 4'(r_pend_idx) : 4'd0;
                    n_out.expiry_count = r_pend_vld ? 32'(r_pend_cnt) : 32'd0;
                    n_out.ticks_so_far = 32'(r_tick);
                    n_out.ok           = 1'b1;
                    n_out.delay_busy   = (r_delay != '0);
                    n_out.last         = 1'b1;
                    n_pend_vld         = 1'b0;
                    n_state            = S_IDLE;
                end
            end

            S_CMD: begin
                if (out_free) begin
                    case (r_func)
                        FUNC_INIT: begin
                            if (cmd_valid && !r_running[r_proc]) begin
                                ram_we            = 1'b1;
                                ram_wdata         = {rd_reload, {CW{1'b0}}, {CW{1'b0}}};
                                n_written[r_proc] = 1'b1;
                                cmd_ok            = 1'b1;
                            end
                        end
                        FUNC_RUN: begin
                            if (cmd_valid && !r_running[r_proc]) begin
                                ram_we            = 1'b1;
                                ram_wdata         = {r_val, r_val, {CW{1'b0}}};
                                n_written[r_proc] = 1'b1;
                                n_running[r_proc] = 1'b1;
                                cmd_ok            = 1'b1;
                            end
                        end
                        FUNC_STOP: begin
                            if (cmd_valid) begin
                                n_running[r_proc] = 1'b0;
                                cmd_ok            = 1'b1;
                            end
                        end
                        FUNC_DELAY: begin
                            n_delay = r_val;
                            cmd_ok  = 1'b1;
                        end
                        default: begin
                            cmd_ok = 1'b0;
                        end
                    endcase
                    n_out_vld          = 1'b1;
                    n_out.kind         = KIND_ACK;
                    n_out.which_timer  = (r_func inside {FUNC_INIT, FUNC_RUN, FUNC_STOP}) ?
                                         r_cidx : 4'd0;
                    n_out.expiry_count = 32'd0;
                    n_out.ticks_so_far = 32'(r_tick);
                    n_out.ok           = cmd_ok;
                    n_out.delay_busy   = (n_delay != '0);
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new active count recreates the bank, so every timer stops
        if (i_cfg_we) begin
            n_active  = i_cfg_data;
            n_running = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_running  <= '0;
            r_written  <= '0;
            r_tick     <= '0;
            r_delay    <= '0;
            r_issue    <= '0;
            r_proc_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_running  <= n_running;
            r_written  <= n_written;
            r_tick     <= n_tick;
            r_delay    <= n_delay;
            r_issue    <= n_issue;
            r_proc_vld <= n_proc_vld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc     <= n_proc;
        r_pend_idx <= n_pend_idx;
        r_pend_cnt <= n_pend_cnt;
        r_out      <= n_out;
        r_func     <= n_func;
        r_cidx     <= n_cidx;
        r_val      <= n_val;
    end

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SCAN || r_state == S_CMD))
        else $error("entry write outside scan or command");

    a_stall_holds_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stall |-> (!ram_re && !ram_we))
        else $error("scan advanced while stalled");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("held expiry outside a tick");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_proc_vld)
        else $error("read in flight while idle");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= ACT_W'(MAX_ACT))
        else $error("scan index beyond timer count");

endmodule

`default_nettype wire
